### hw/rtl/qbz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qbz_pkg;

  localparam int unsigned MaxTableLength = 65536;
  localparam int unsigned IdxW    = 17;
  localparam int unsigned XW      = 24;
  localparam int unsigned YW      = 32;
  localparam int unsigned RadW    = 62;
  localparam int unsigned RootW   = 31;
  localparam int unsigned SremW   = 33;
  localparam int unsigned DenW    = 33;
  localparam int unsigned QW      = 25;
  localparam int unsigned SqCells = RootW;
  localparam int unsigned DvCells = QW;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotRise  = 2'd1;
  localparam logic [1:0] StCtrlOut  = 2'd2;
  localparam logic [1:0] StIdxRange = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0]        sample_index;
    logic [XW-1:0]          seg_x_start;
    logic [XW-1:0]          seg_x_ctrl;
    logic [XW-1:0]          seg_x_end;
    logic signed [YW-1:0]   seg_y_start;
    logic signed [YW-1:0]   seg_y_ctrl;
    logic signed [YW-1:0]   seg_y_end;
  } item_t;

  typedef struct packed {
    logic signed [YW-1:0] curve_value;
    logic [1:0]           status;
  } result_t;

  // side data that rides along the cell chains
  typedef struct packed {
    logic [24:0]          b;
    logic [24:0]          d;
    logic signed [YW-1:0] ys;
    logic signed [YW-1:0] yc;
    logic signed [YW-1:0] ye;
    logic [1:0]           status;
    logic                 t_zero;
    logic                 t_one;
  } ctx_t;

endpackage
`default_nettype wire

### hw/rtl/quadratic_bezier_y_for_x.sv
`timescale 1ns / 1ps
`default_nettype none
// Port        Dir  Beat / meaning
// item_i      in   segment and sample index, taken when start_i && !busy_o
// start_i     in   request strobe
// busy_o      out  tied low, a new beat is taken every cycle
// result_o    out  curve value and status, valid only while done_o
// done_o      out  one-cycle result strobe, cannot be held off
// cfg_we_i    in   writes cfg_wdata_i into table_length
//
// Fully pipelined: one item per cycle, no stall from accept to done_o.
// The pipe holds the 31-cell square root chain and the 25-cell divider.
// Reset clears the valid bits and sets table_length to 4096.
// No stall path: results leave in accept order, one cycle each.
module quadratic_bezier_y_for_x (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  qbz_pkg::item_t                  item_i,
  output logic                            busy_o,
  output logic                            done_o,
  output qbz_pkg::result_t                result_o,
  input  wire                             cfg_we_i,
  input  wire [qbz_pkg::IdxW-1:0]         cfg_wdata_i
);

  localparam int unsigned Latency = 3 + qbz_pkg::SqCells + 1 + qbz_pkg::DvCells + 5;
  localparam logic [24:0] TOne = 25'd1 << 24;
  localparam logic [qbz_pkg::IdxW-1:0] LimMax = qbz_pkg::IdxW'(qbz_pkg::MaxTableLength);

  logic [qbz_pkg::IdxW-1:0] tbl_len_q;
  logic                     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_len_q <= qbz_pkg::IdxW'(4096);
    end else if (cfg_we_i) begin
      tbl_len_q <= cfg_wdata_i;
    end
  end

  // stage 1: checks and setup
  logic [qbz_pkg::IdxW-1:0] limit;
  logic [24:0]              xpos, xs_e, xc_e, xe_e, cdiff;
  logic [1:0]               st_d;
  qbz_pkg::ctx_t            ctx1_d, ctx1_q;
  logic signed [26:0]       a1_d, a1_q;
  logic                     v1_q;

  always_comb begin
    limit = (tbl_len_q > LimMax) ? LimMax : tbl_len_q;
    xpos  = {item_i.sample_index, 8'b0};
    xs_e  = {1'b0, item_i.seg_x_start};
    xc_e  = {1'b0, item_i.seg_x_ctrl};
    xe_e  = {1'b0, item_i.seg_x_end};
    if (xe_e <= xs_e) begin
      st_d = qbz_pkg::StNotRise;
    end else if (xc_e < xs_e || xc_e > xe_e) begin
      st_d = qbz_pkg::StCtrlOut;
    end else if (item_i.sample_index > limit || xpos > xe_e || xpos < xs_e) begin
      st_d = qbz_pkg::StIdxRange;
    end else begin
      st_d = qbz_pkg::StOk;
    end
    cdiff         = xc_e - xs_e;
    a1_d          = $signed({3'b0, item_i.seg_x_start}) - $signed({2'b0, item_i.seg_x_ctrl, 1'b0})
                    + $signed({3'b0, item_i.seg_x_end});
    ctx1_d.b      = {cdiff[23:0], 1'b0};
    ctx1_d.d      = xpos - xs_e;
    ctx1_d.ys     = item_i.seg_y_start;
    ctx1_d.yc     = item_i.seg_y_ctrl;
    ctx1_d.ye     = item_i.seg_y_end;
    ctx1_d.status = st_d;
    ctx1_d.t_zero = xpos == xs_e;
    ctx1_d.t_one  = xpos == xe_e;
  end

  // stage 2: products, stage 3: discriminant
  qbz_pkg::ctx_t              ctx2_q, ctx3_q;
  logic [49:0]                bb2_q;
  logic signed [52:0]         ad2_q;
  logic signed [55:0]         disc;
  logic [qbz_pkg::RadW-1:0]   rad3_d, rad3_q;
  logic                       v2_q, v3_q;

  always_comb begin
    disc   = $signed({6'b0, bb2_q}) + $signed({ad2_q[52], ad2_q, 2'b00});
    rad3_d = disc[55] ? '0 : {disc[51:0], 10'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q <= ctx1_d;
    a1_q   <= a1_d;
    ctx2_q <= ctx1_q;
    bb2_q  <= ctx1_q.b * ctx1_q.b;
    ad2_q  <= a1_q * $signed({1'b0, ctx1_q.d});
    ctx3_q <= ctx2_q;
    rad3_q <= rad3_d;
  end

  // square root chain
  logic                       sq_v    [qbz_pkg::SqCells+1];
  qbz_pkg::ctx_t              sq_ctx  [qbz_pkg::SqCells+1];
  logic [qbz_pkg::RadW-1:0]   sq_rad  [qbz_pkg::SqCells+1];
  logic [qbz_pkg::SremW-1:0]  sq_rem  [qbz_pkg::SqCells+1];
  logic [qbz_pkg::RootW-1:0]  sq_root [qbz_pkg::SqCells+1];

  assign sq_v[0]    = v3_q;
  assign sq_ctx[0]  = ctx3_q;
  assign sq_rad[0]  = rad3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < qbz_pkg::SqCells; i++) begin : g_sq
    qbz_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .ctx_i   (sq_ctx[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_v[i+1]),
      .ctx_o   (sq_ctx[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  // denominator stage
  qbz_pkg::ctx_t              sqo, ctx4_d, ctx4_q;
  logic [qbz_pkg::DenW-1:0]   den4_d, den4_q, num4;
  logic                       v4_q;

  always_comb begin
    sqo    = sq_ctx[qbz_pkg::SqCells];
    den4_d = {3'b0, sqo.b, 5'b0} + {2'b0, sq_root[qbz_pkg::SqCells]};
    num4   = {3'b0, sqo.d, 5'b0};
    ctx4_d = sqo;
    ctx4_d.t_zero = sqo.t_zero | (!sqo.t_one && den4_d == '0);
    ctx4_d.t_one  = sqo.t_one | (!sqo.t_zero && den4_d != '0 && num4 >= den4_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= sq_v[qbz_pkg::SqCells];
    end
  end

  always_ff @(posedge clk_i) begin
    ctx4_q <= ctx4_d;
    den4_q <= den4_d;
  end

  // divider chain
  logic                       dv_v   [qbz_pkg::DvCells+1];
  qbz_pkg::ctx_t              dv_ctx [qbz_pkg::DvCells+1];
  logic [qbz_pkg::DenW-1:0]   dv_den [qbz_pkg::DvCells+1];
  logic [qbz_pkg::DenW-1:0]   dv_rem [qbz_pkg::DvCells+1];
  logic [qbz_pkg::QW-1:0]     dv_q   [qbz_pkg::DvCells+1];

  assign dv_v[0]   = v4_q;
  assign dv_ctx[0] = ctx4_q;
  assign dv_den[0] = den4_q;
  assign dv_rem[0] = {3'b0, ctx4_q.d, 5'b0};
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < qbz_pkg::DvCells; i++) begin : g_dv
    qbz_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[i]),
      .ctx_i   (dv_ctx[i]),
      .den_i   (dv_den[i]),
      .rem_i   (dv_rem[i]),
      .q_i     (dv_q[i]),
      .valid_o (dv_v[i+1]),
      .ctx_o   (dv_ctx[i+1]),
      .den_o   (dv_den[i+1]),
      .rem_o   (dv_rem[i+1]),
      .q_o     (dv_q[i+1])
    );
  end

  // t, weights, products, sum
  qbz_pkg::ctx_t        dvo, ctx5_q, ctx6_q, ctx7_q, ctx8_q;
  logic [24:0]          t5_d, t5_q, u5_q, qv;
  logic [49:0]          uu6_q, tt6_q;
  logic [30:0]          w0_7_q, w2_7_q;
  logic signed [31:0]   w1_7_q;
  logic [49:0]          uu_r, tt_r;
  logic signed [63:0]   p0_8_q, p1_8_q, p2_8_q;
  logic signed [65:0]   acc;
  logic signed [35:0]   yv;
  logic signed [31:0]   ysat;
  logic                 v5_q, v6_q, v7_q, v8_q;

  always_comb begin
    dvo = dv_ctx[qbz_pkg::DvCells];
    qv  = dv_q[qbz_pkg::DvCells];
    if (dvo.t_zero) begin
      t5_d = '0;
    end else if (dvo.t_one || qv > TOne) begin
      t5_d = TOne;
    end else begin
      t5_d = qv;
    end
    uu_r = uu6_q + 50'd131072;
    tt_r = tt6_q + 50'd131072;
    acc  = 66'(p0_8_q) + 66'(p1_8_q) + 66'(p2_8_q) + (66'sd1 <<< 29);
    yv   = acc[65:30];
    if (yv > 36'sd2147483647) begin
      ysat = 32'sh7fffffff;
    end else if (yv < -36'sd2147483648) begin
      ysat = 32'sh80000000;
    end else begin
      ysat = yv[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v5_q   <= dv_v[qbz_pkg::DvCells];
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      done_o <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx5_q <= dvo;
    t5_q   <= t5_d;
    u5_q   <= TOne - t5_d;
    ctx6_q <= ctx5_q;
    uu6_q  <= u5_q * u5_q;
    tt6_q  <= t5_q * t5_q;
    ctx7_q <= ctx6_q;
    w0_7_q <= uu_r[48:18];
    w2_7_q <= tt_r[48:18];
    w1_7_q <= (32'sd1 <<< 30) - $signed({1'b0, uu_r[48:18]}) - $signed({1'b0, tt_r[48:18]});
    ctx8_q <= ctx7_q;
    p0_8_q <= $signed({1'b0, w0_7_q}) * ctx7_q.ys;
    p1_8_q <= w1_7_q * ctx7_q.yc;
    p2_8_q <= $signed({1'b0, w2_7_q}) * ctx7_q.ye;
    result_o.status      <= ctx8_q.status;
    result_o.curve_value <= (ctx8_q.status == qbz_pkg::StOk) ? ysat : '0;
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != qbz_pkg::StOk |-> result_o.curve_value == '0)
    else $error("nonzero value with error status");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result missing after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without matching accept");

endmodule
`default_nettype wire

### hw/rtl/qbz_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module qbz_sqrt_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             valid_i,
  input  qbz_pkg::ctx_t                   ctx_i,
  input  wire [qbz_pkg::RadW-1:0]         rad_i,
  input  wire [qbz_pkg::SremW-1:0]        rem_i,
  input  wire [qbz_pkg::RootW-1:0]        root_i,
  output logic                            valid_o,
  output qbz_pkg::ctx_t                   ctx_o,
  output logic [qbz_pkg::RadW-1:0]        rad_o,
  output logic [qbz_pkg::SremW-1:0]       rem_o,
  output logic [qbz_pkg::RootW-1:0]       root_o
);

  logic [qbz_pkg::SremW+1:0] rem_sh;
  logic [qbz_pkg::SremW+1:0] trial;
  logic                      take;

  always_comb begin
    rem_sh = {rem_i, rad_i[qbz_pkg::RadW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_o  <= ctx_i;
    rad_o  <= {rad_i[qbz_pkg::RadW-3:0], 2'b00};
    rem_o  <= take ? qbz_pkg::SremW'(rem_sh - trial) : qbz_pkg::SremW'(rem_sh);
    root_o <= {root_i[qbz_pkg::RootW-2:0], take};
  end

endmodule
`default_nettype wire

### hw/rtl/qbz_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module qbz_div_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  qbz_pkg::ctx_t                ctx_i,
  input  wire [qbz_pkg::DenW-1:0]      den_i,
  input  wire [qbz_pkg::DenW-1:0]      rem_i,
  input  wire [qbz_pkg::QW-1:0]        q_i,
  output logic                         valid_o,
  output qbz_pkg::ctx_t                ctx_o,
  output logic [qbz_pkg::DenW-1:0]     den_o,
  output logic [qbz_pkg::DenW-1:0]     rem_o,
  output logic [qbz_pkg::QW-1:0]       q_o
);

  logic [qbz_pkg::DenW:0] rem_sh;
  logic                   take;

  always_comb begin
    rem_sh = {rem_i, 1'b0};
    take   = rem_sh >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_o <= ctx_i;
    den_o <= den_i;
    rem_o <= take ? qbz_pkg::DenW'(rem_sh - {1'b0, den_i}) : qbz_pkg::DenW'(rem_sh);
    q_o   <= {q_i[qbz_pkg::QW-2:0], take};
  end

endmodule
`default_nettype wire

### tb/sv/bezier_checker.sv
`timescale 1ns / 1ps
module bezier_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_o,
  input  qbz_pkg::item_t            item_i,
  input  logic                      done_o,
  input  qbz_pkg::result_t          result_o,
  input  logic                      cfg_we_i,
  input  logic [16:0]               cfg_wdata_i,
  output int                        err_cnt_o,
  output int                        pending_o
);

  localparam logic [63:0] TOne = 64'd1 << 24;

  logic [16:0]      tbl_len;
  qbz_pkg::result_t curve_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] solve_param(longint xs, longint xc, longint xe, longint xp);
    longint a, b, d, disc;
    logic [63:0] den, t;
    if (xp == xs) return 0;
    if (xp == xe) return TOne;
    a = xs - 2 * xc + xe;
    b = 2 * (xc - xs);
    d = xp - xs;
    if (a != 0) begin
      disc = b * b + 4 * a * d;
      if (disc < 0) disc = 0;
      den = (64'(b) << 5) + int_sqrt(64'(disc) << 10);
      if (den == 0) return 0;
      t = (64'(2 * d) << 29) / den;
    end else begin
      if (b <= 0) return 0;
      t = (64'(d) << 24) / 64'(b);
    end
    return (t > TOne) ? TOne : t;
  endfunction

  function automatic qbz_pkg::result_t predict_curve(qbz_pkg::item_t it, logic [16:0] tl);
    qbz_pkg::result_t r;
    longint xs, xc, xe, xp, lim, w0, w1, w2, acc, y;
    logic [63:0] t, u;
    xs = it.seg_x_start;
    xc = it.seg_x_ctrl;
    xe = it.seg_x_end;
    xp = longint'(it.sample_index) << 8;
    lim = (tl > qbz_pkg::MaxTableLength) ? qbz_pkg::MaxTableLength : tl;
    r.status = qbz_pkg::StOk;
    r.curve_value = 0;
    if (xe <= xs) r.status = qbz_pkg::StNotRise;
    else if (xc < xs || xc > xe) r.status = qbz_pkg::StCtrlOut;
    else if (it.sample_index > lim || xp > xe || xp < xs) r.status = qbz_pkg::StIdxRange;
    if (r.status == qbz_pkg::StOk) begin
      t = solve_param(xs, xc, xe, xp);
      u = TOne - t;
      w0 = longint'((u * u + (64'd1 << 17)) >> 18);
      w2 = longint'((t * t + (64'd1 << 17)) >> 18);
      w1 = (longint'(1) << 30) - w0 - w2;
      acc = w0 * longint'(it.seg_y_start) + w1 * longint'(it.seg_y_ctrl)
          + w2 * longint'(it.seg_y_end) + (longint'(1) << 29);
      y = acc >>> 30;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      r.curve_value = y[31:0];
    end
    return r;
  endfunction

  assign pending_o = curve_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    qbz_pkg::result_t exp_r;
    if (!rst_ni) begin
      tbl_len <= 17'd4096;
      err_cnt_o <= 0;
      curve_q.delete();
    end else begin
      if (start_i && !busy_o) curve_q.push_back(predict_curve(item_i, tbl_len));
      if (cfg_we_i) tbl_len <= cfg_wdata_i;
      if (done_o) begin
        if (curve_q.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          if (err_cnt_o < 10) $display("unexpected result beat %h", result_o);
        end else begin
          exp_r = curve_q.pop_front();
          if (exp_r.status !== result_o.status || exp_r.curve_value !== result_o.curve_value) begin
            err_cnt_o <= err_cnt_o + 1;
            if (err_cnt_o < 10)
              $display("mismatch: exp value %h status %0d, got value %h status %0d",
                       exp_r.curve_value, exp_r.status, result_o.curve_value, result_o.status);
          end
        end
      end
    end
  end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  logic             clk_i, rst_ni, start_i, cfg_we_i, busy_o, done_o;
  logic [16:0]      cfg_wdata_i;
  qbz_pkg::item_t   item_i;
  qbz_pkg::result_t result_o;
  int               err_cnt, pending, idle_cyc;
  logic [16:0]      cur_len;

  quadratic_bezier_y_for_x u_dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o,
    .cfg_we_i, .cfg_wdata_i
  );

  bezier_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .cfg_we_i, .cfg_wdata_i, .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 2000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(qbz_pkg::item_t it, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  task automatic write_len(logic [16:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cur_len = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic qbz_pkg::item_t rand_seg();
    qbz_pkg::item_t it;
    logic [23:0] xs, xe;
    int unsigned span, kind;
    kind = $urandom_range(0, 19);
    it.seg_y_start = $urandom;
    it.seg_y_ctrl = $urandom;
    it.seg_y_end = $urandom;
    if (kind < 3) it.seg_y_ctrl = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    if (kind == 0) begin
      it.sample_index = 17'($urandom);
      it.seg_x_start = 24'($urandom);
      it.seg_x_ctrl = 24'($urandom);
      it.seg_x_end = 24'($urandom);
      return it;
    end
    span = (kind < 5) ? $urandom_range(1, 24'hffffff) : $urandom_range(1, 300000);
    xs = 24'($urandom_range(0, 24'hffffff - span));
    if (kind == 6) xs = 0;
    xe = 24'(xs + span);
    it.seg_x_start = xs;
    it.seg_x_end = xe;
    it.seg_x_ctrl = 24'($urandom_range(xs, xe));
    if (kind == 7) it.seg_x_ctrl = 24'((xs + xe) / 2);
    if (kind == 8) it.seg_x_ctrl = xs;
    if (kind == 9) it.seg_x_ctrl = xe;
    it.sample_index = 17'($urandom_range((xs + 255) >> 8, xe >> 8));
    if (kind == 10) it.sample_index = 17'($urandom_range(0, 17'h1ffff));
    if (kind == 11 && $urandom_range(0, 1)) it.sample_index = 17'(xs >> 8);
    return it;
  endfunction

  initial begin
    qbz_pkg::item_t it;
    logic [16:0] lens[6];
    lens = '{17'd1, 17'd65536, 17'h1ffff, 17'd4096, 17'd300, 17'd65535};
    rst_ni = 0; start_i = 0; cfg_we_i = 0; cfg_wdata_i = 0; item_i = '0;
    cur_len = 17'd4096;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed beats
    it = '{17'd2, 24'h100, 24'h180, 24'h400, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000};
    send_beat(it, 0);
    it.sample_index = 1; send_beat(it, 0);
    it.sample_index = 4; send_beat(it, 0);
    it.sample_index = 5; send_beat(it, 0);
    it.sample_index = 0; send_beat(it, 0);
    it.seg_x_ctrl = 24'h280; it.sample_index = 3; send_beat(it, 0);
    it.seg_x_ctrl = 24'h80; send_beat(it, 0);
    it.seg_x_ctrl = 24'h500; send_beat(it, 0);
    it.seg_x_end = 24'h100; send_beat(it, 0);
    it.seg_x_end = 24'h0; send_beat(it, 0);
    it = '{17'd4096, 24'h0, 24'h0, 24'hffffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
           32'sh7fff_ffff};
    send_beat(it, 0);
    it.sample_index = 4097; send_beat(it, 0);
    it.seg_y_start = 32'sh8000_0000; it.seg_y_ctrl = 32'sh8000_0000;
    it.seg_y_end = 32'sh8000_0000; it.sample_index = 17'd65535; send_beat(it, 0);
    it.seg_x_ctrl = 24'hffffff; it.sample_index = 17'd100; send_beat(it, 0);
    it.seg_x_ctrl = 24'h7fffff; it.seg_y_ctrl = 32'sh7fff_ffff; send_beat(it, 0);
    it.sample_index = 17'h1ffff; send_beat(it, 0);
    it = '{17'd200, 24'h0, 24'hffffff, 24'hffffff, 32'sh7fff_ffff, 32'sh8000_0000,
           32'sh7fff_ffff};
    send_beat(it, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_len(lens[ph]);
      for (int n = 0; n < 275; n++) begin
        it = rand_seg();
        if ($urandom_range(0, 3) == 0) it.sample_index = 17'($urandom_range(0, cur_len));
        send_beat(it, ph < 5);
      end
      drain();
    end
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
hw/rtl/qbz_pkg.sv
hw/rtl/qbz_sqrt_cell.sv
hw/rtl/qbz_div_cell.sv
hw/rtl/quadratic_bezier_y_for_x.sv
tb/sv/bezier_checker.sv
tb/sv/testbench.sv
